### hdl/cmcs_pkg.sv
// shared types and constants for the constrained minimum-cost selector
// no dependencies; used by cmcs_ctrl, cmcs_dp and constrained_min_cost_selector
`timescale 1ns / 1ps

package cmcs_pkg;

    localparam int MAX_SLOTS   = 3;
    localparam int SLOT_W      = 2;
    localparam int UNIT_W      = 8;
    localparam int QTY_W       = 16;
    localparam int COST_W      = 31;
    localparam int PROD_W      = 2 * QTY_W;
    localparam int PAIRS_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
    localparam logic [PAIRS_W-1:0] PAIRS_MAX = {PAIRS_W{1'b1}};

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_REQUEST_COUNT = 3'd0;
    localparam cfg_idx_t CFG_REQ0_UNIT     = 3'd1;
    localparam cfg_idx_t CFG_REQ0_AMOUNT   = 3'd2;
    localparam cfg_idx_t CFG_REQ1_UNIT     = 3'd3;
    localparam cfg_idx_t CFG_REQ1_AMOUNT   = 3'd4;
    localparam cfg_idx_t CFG_REQ2_UNIT     = 3'd5;
    localparam cfg_idx_t CFG_REQ2_AMOUNT   = 3'd6;

    // element i holds the register index of slot i
    localparam logic [MAX_SLOTS-1:0][CFG_IDX_W-1:0] CFG_UNIT_IDX =
        {CFG_REQ2_UNIT, CFG_REQ1_UNIT, CFG_REQ0_UNIT};
    localparam logic [MAX_SLOTS-1:0][CFG_IDX_W-1:0] CFG_AMOUNT_IDX =
        {CFG_REQ2_AMOUNT, CFG_REQ1_AMOUNT, CFG_REQ0_AMOUNT};

    typedef struct packed {
        logic              func;
        logic [UNIT_W-1:0] offer_unit;
        logic [QTY_W-1:0]  offer_price;
        logic [QTY_W-1:0]  offer_amount;
        logic              last_offer;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] best_cost;
        logic              resource_qualified;
        logic              new_best;
        logic              found_any;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              new_query;
        logic              issue;
        logic              accum;
        logic              eval;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [SLOT_W-1:0] n_active;
        logic              in_last;
        logic              out_busy;
    } dp_stat_t;

endpackage

### hdl/cmcs_ctrl.sv
// sequencer for the selector: walks the active request slots, drains, evaluates
// depends on cmcs_pkg
`timescale 1ns / 1ps

module cmcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_func,
    input  cmcs_pkg::dp_stat_t stat,
    output cmcs_pkg::dp_cmd_t  cmd
);
    import cmcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EVAL
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              accept;

    // no transfer is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        case (state_reg)
            ST_IDLE: begin
                slot_next = '0;
                if (accept && !s_func) begin
                    if (stat.n_active != '0) begin
                        state_next = ST_RUN;
                    end else begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_RUN: begin
                if (slot_reg == stat.n_active - SLOT_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = stat.in_last ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                // hold until the output register can take the result
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb begin
        cmd.load      = accept;
        cmd.new_query = accept && s_func;
        cmd.issue     = (state_reg == ST_RUN);
        // product of the previous slot lands in the cycle after its issue
        cmd.accum     = ((state_reg == ST_RUN) && (slot_reg != '0)) ||
                        ((state_reg == ST_DRAIN) && (stat.n_active != '0));
        cmd.eval      = (state_reg == ST_EVAL) && !stat.out_busy;
        cmd.slot      = slot_reg;
    end

endmodule

### hdl/cmcs_dp.sv
// datapath: request registers, shared multiplier, saturating cost, minimum tracking
// depends on cmcs_pkg
`timescale 1ns / 1ps

module cmcs_dp #(
    parameter int REQUEST_SLOTS = cmcs_pkg::MAX_SLOTS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [cmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  cmcs_pkg::in_item_t           s_data,
    input  cmcs_pkg::dp_cmd_t            cmd,
    output cmcs_pkg::dp_stat_t           stat,
    input  logic                         m_ready,
    output logic                         m_valid,
    output cmcs_pkg::out_item_t          m_data
);
    import cmcs_pkg::*;

    logic [SLOT_W-1:0]  request_count_reg;
    logic [UNIT_W-1:0]  req_unit_reg   [REQUEST_SLOTS];
    logic [QTY_W-1:0]   req_amount_reg [REQUEST_SLOTS];

    logic [UNIT_W-1:0]  offer_unit_reg;
    logic [QTY_W-1:0]   offer_price_reg;
    logic [QTY_W-1:0]   offer_amount_reg;
    logic               last_reg;

    logic [PROD_W-1:0]  prod_reg;
    logic               match_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [PAIRS_W-1:0] pairs_reg;
    logic [COST_W-1:0]  min_reg;
    logic               any_reg;

    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [SLOT_W-1:0]  n_active;
    logic [UNIT_W-1:0]  sel_unit;
    logic [QTY_W-1:0]   sel_amount;
    logic               slot_match;
    logic [COST_W+1:0]  cost_sum;
    logic [COST_W-1:0]  cost_acc;
    logic               qualified;
    logic               better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            request_count_reg <= '0;
            for (int i = 0; i < REQUEST_SLOTS; i++) begin
                req_unit_reg[i]   <= '0;
                req_amount_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == CFG_REQUEST_COUNT) begin
                request_count_reg <= cfg_data[SLOT_W-1:0];
            end
            for (int i = 0; i < REQUEST_SLOTS; i++) begin
                if (cfg_index == CFG_UNIT_IDX[i]) begin
                    req_unit_reg[i] <= cfg_data[UNIT_W-1:0];
                end
                if (cfg_index == CFG_AMOUNT_IDX[i]) begin
                    req_amount_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign n_active = (request_count_reg > SLOT_W'(REQUEST_SLOTS)) ?
                      SLOT_W'(REQUEST_SLOTS) : request_count_reg;

    always_comb begin
        sel_unit   = '0;
        sel_amount = '0;
        for (int i = 0; i < REQUEST_SLOTS; i++) begin
            if (cmd.slot == SLOT_W'(i)) begin
                sel_unit   = req_unit_reg[i];
                sel_amount = req_amount_reg[i];
            end
        end
    end

    assign slot_match = (sel_unit == offer_unit_reg) && (sel_amount <= offer_amount_reg);

    assign cost_sum = {2'b00, cost_reg} + {1'b0, prod_reg};
    assign cost_acc = (cost_sum > {2'b00, COST_MAX}) ? COST_MAX : cost_sum[COST_W-1:0];

    assign qualified = (pairs_reg >= {{(PAIRS_W-SLOT_W){1'b0}}, n_active});
    assign better    = qualified && (cost_reg < min_reg);

    // offer capture and multiplier stage
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            offer_unit_reg   <= s_data.offer_unit;
            offer_price_reg  <= s_data.offer_price;
            offer_amount_reg <= s_data.offer_amount;
            last_reg         <= s_data.last_offer;
        end
        if (cmd.issue) begin
            prod_reg  <= slot_match ? sel_amount * offer_price_reg : '0;
            match_reg <= slot_match;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_reg      <= '0;
            pairs_reg     <= '0;
            min_reg       <= COST_MAX;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.new_query) begin
                cost_reg  <= '0;
                pairs_reg <= '0;
                min_reg   <= COST_MAX;
                any_reg   <= 1'b0;
            end else if (cmd.accum) begin
                cost_reg <= cost_acc;
                if (match_reg && (pairs_reg != PAIRS_MAX)) begin
                    pairs_reg <= pairs_reg + PAIRS_W'(1);
                end
            end else if (cmd.eval) begin
                if (better) begin
                    min_reg <= cost_reg;
                    any_reg <= 1'b1;
                end
                cost_reg      <= '0;
                pairs_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            out_reg.best_cost          <= better ? cost_reg : min_reg;
            out_reg.resource_qualified <= qualified;
            out_reg.new_best           <= better;
            out_reg.found_any          <= better || any_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        stat.n_active = n_active;
        stat.in_last  = last_reg;
        stat.out_busy = out_valid_reg && !m_ready;
    end

endmodule

### hdl/constrained_min_cost_selector.sv
// top level of the constrained minimum-cost selector
// depends on cmcs_pkg, cmcs_ctrl, cmcs_dp
//
// channel   direction  payload            transfer when
// s_        in         cmcs_pkg::in_item_t   s_valid & s_ready
// m_        out        cmcs_pkg::out_item_t  m_valid & m_ready
// cfg_      in         cfg_index, cfg_data   cfg_valid & cfg_ready
//
// a new-query item clears the running query; an offer is captured, issued to each
// active request slot in turn, drained, and evaluated after the last offer of a resource
// the single multiplier is shared across request slots, one slot per cycle
// the result sits in an output register, so the next offer is taken while it waits;
// only the evaluate cycle holds when the previous result has not been taken
// reset is synchronous on aresetn low; control registers clear, the minimum to all ones
`timescale 1ns / 1ps

module constrained_min_cost_selector #(
    parameter int REQUEST_SLOTS = cmcs_pkg::MAX_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cmcs_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output cmcs_pkg::out_item_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cmcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cmcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cmcs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = aresetn;

    cmcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .stat    (stat),
        .cmd     (cmd)
    );

    cmcs_dp #(
        .REQUEST_SLOTS (REQUEST_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
